/* rtl/ird_pkg.sv */
// ----------------------------------------------------------------------------
// ird_pkg: shared types and constants for the infrared distance linearizer
// Holds the calibration table and the segment reciprocals. It also holds the
// transaction record that passes between the front end, the queue and the
// back end.
// ----------------------------------------------------------------------------
package ird_pkg;

   localparam int unsigned POINTS      = 13;
   localparam int unsigned SEGMENTS    = POINTS - 1;
   localparam int unsigned SAMPLE_W    = 12;
   localparam int unsigned DIST_W      = 7;
   localparam int unsigned SEG_W       = 4;
   localparam int unsigned DELTA_W     = 11;
   localparam int unsigned SLOPE_W     = 4;
   localparam int unsigned NUM_W       = DELTA_W + SLOPE_W;
   localparam int unsigned RECIP_SHIFT = 26;
   localparam int unsigned RECIP_W     = 22;
   localparam int unsigned PROD_W      = NUM_W + RECIP_W;
   localparam int unsigned CSR_INDEX_W = 4;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [DIST_W-1:0]   dist_type;
   typedef logic [SEG_W-1:0]    seg_type;
   typedef logic [DELTA_W-1:0]  delta_type;
   typedef logic [SLOPE_W-1:0]  slope_type;
   typedef logic [RECIP_W-1:0]  recip_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Falling converter codes paired with rising distances in centimetres.
   localparam sample_type CODE_TABLE [POINTS] = '{
      12'd4095, 12'd3775, 12'd2400, 12'd1770, 12'd1330, 12'd1064, 12'd915,
      12'd805,  12'd740,  12'd700,  12'd630,  12'd590,  12'd560};
   localparam dist_type DIST_TABLE [POINTS] = '{
      7'd0,  7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35,
      7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd65};

   localparam dist_type MISS_DISTANCE = DIST_TABLE[POINTS-1];

   // Rounded-up reciprocals of each segment's code span, scaled by 2^26. The
   // numerator never exceeds 13740, so the product error stays below the
   // smallest fractional step of any quotient and no correction is needed.
   localparam int unsigned RECIP_ONE = 32'd1 << RECIP_SHIFT;
   localparam recip_type RECIP_TABLE [SEGMENTS] = '{
      RECIP_W'((RECIP_ONE + 320  - 1) / 320),
      RECIP_W'((RECIP_ONE + 1375 - 1) / 1375),
      RECIP_W'((RECIP_ONE + 630  - 1) / 630),
      RECIP_W'((RECIP_ONE + 440  - 1) / 440),
      RECIP_W'((RECIP_ONE + 266  - 1) / 266),
      RECIP_W'((RECIP_ONE + 149  - 1) / 149),
      RECIP_W'((RECIP_ONE + 110  - 1) / 110),
      RECIP_W'((RECIP_ONE + 65   - 1) / 65),
      RECIP_W'((RECIP_ONE + 40   - 1) / 40),
      RECIP_W'((RECIP_ONE + 70   - 1) / 70),
      RECIP_W'((RECIP_ONE + 40   - 1) / 40),
      RECIP_W'((RECIP_ONE + 30   - 1) / 30)};

   localparam csr_index_type CSR_MIN_DISTANCE = 4'd0;
   localparam csr_index_type CSR_RANGE_LIMIT  = 4'd1;

   localparam dist_type MIN_DISTANCE_RESET = 7'd10;
   localparam dist_type RANGE_LIMIT_RESET  = 7'd51;

   // One classified sample on its way to the arithmetic.
   typedef struct packed {
      logic      miss;
      seg_type   seg;
      delta_type delta;
      slope_type slope;
      dist_type  base;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      dist_type min_distance;
      dist_type range_limit;
   } cfg_type;

endpackage

/* rtl/ird_front.sv */
// ----------------------------------------------------------------------------
// ird_front: sample intake and segment classification
// Compares the sample against every table segment at once and registers the
// segment, the offset into it and the segment's slope.
// ----------------------------------------------------------------------------
module ird_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ird_pkg::sample_type adc_sample,
   input  logic                queue_full,
   output logic                push,
   output ird_pkg::item_type   push_item
);

   logic              valid_ff;
   logic              valid_in;
   ird_pkg::item_type item_ff;
   ird_pkg::item_type item_in;
   logic              accept;

   // Nothing is taken while reset is held, so busy stays high throughout it.
   assign busy   = reset || (valid_ff && queue_full);
   assign accept = start && !busy;
   assign push   = valid_ff && !queue_full;
   assign push_item = item_ff;

   // At most one segment can match because the codes fall strictly.
   always_comb begin
      item_in.miss  = 1'b1;
      item_in.seg   = '0;
      item_in.delta = '0;
      item_in.slope = '0;
      item_in.base  = ird_pkg::MISS_DISTANCE;
      for (int k = 0; k < ird_pkg::SEGMENTS; k++) begin
         if (adc_sample <= ird_pkg::CODE_TABLE[k] && adc_sample > ird_pkg::CODE_TABLE[k+1]) begin
            item_in.miss  = 1'b0;
            item_in.seg   = ird_pkg::SEG_W'(k);
            item_in.delta = ird_pkg::DELTA_W'(ird_pkg::CODE_TABLE[k] - adc_sample);
            item_in.slope = ird_pkg::SLOPE_W'(ird_pkg::DIST_TABLE[k+1] - ird_pkg::DIST_TABLE[k]);
            item_in.base  = ird_pkg::DIST_TABLE[k];
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (!busy) begin
         valid_in = start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/ird_queue.sv */
// ----------------------------------------------------------------------------
// ird_queue: short FIFO between classification and arithmetic
// Decouples the front end from the back end; the head is visible at once.
// ----------------------------------------------------------------------------
module ird_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ird_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output ird_pkg::head_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ird_pkg::item_type mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/ird_back.sv */
// ----------------------------------------------------------------------------
// ird_back: interpolation arithmetic and result register
// Three stages: offset times slope, times segment reciprocal, then the
// base addition, floor clamp and range compare into the result register.
// ----------------------------------------------------------------------------
module ird_back (
   input  logic                clock,
   input  logic                reset,
   input  ird_pkg::head_type   head,
   output logic                pop,
   input  ird_pkg::cfg_type    cfg,
   output logic                rsp_valid,
   output ird_pkg::dist_type   rsp_distance_cm,
   output logic                rsp_out_of_range,
   output logic                rsp_no_segment,
   output ird_pkg::seg_type    rsp_segment_index
);

   logic                        s1_valid_ff;
   logic [ird_pkg::NUM_W-1:0]   s1_num_ff;
   logic [ird_pkg::NUM_W-1:0]   s1_num_in;
   ird_pkg::recip_type          s1_recip_ff;
   ird_pkg::dist_type           s1_base_ff;
   logic                        s1_miss_ff;
   ird_pkg::seg_type            s1_seg_ff;

   logic                        s2_valid_ff;
   ird_pkg::slope_type          s2_quot_ff;
   ird_pkg::slope_type          s2_quot_in;
   logic [ird_pkg::PROD_W-1:0]  s2_prod;
   ird_pkg::dist_type           s2_base_ff;
   logic                        s2_miss_ff;
   ird_pkg::seg_type            s2_seg_ff;

   logic                        valid_ff;
   ird_pkg::dist_type           dist_ff;
   ird_pkg::dist_type           dist_in;
   ird_pkg::dist_type           sum;
   logic                        oor_ff;
   logic                        oor_in;
   logic                        miss_ff;
   ird_pkg::seg_type            seg_ff;

   // The back end never stalls, so the queue head is taken whenever present.
   assign pop = head.valid;

   assign s1_num_in = ird_pkg::NUM_W'(head.item.delta) * ird_pkg::NUM_W'(head.item.slope);

   assign s2_prod    = ird_pkg::PROD_W'(s1_num_ff) * ird_pkg::PROD_W'(s1_recip_ff);
   assign s2_quot_in = s2_prod[ird_pkg::RECIP_SHIFT +: ird_pkg::SLOPE_W];

   assign sum     = s2_base_ff + ird_pkg::DIST_W'(s2_quot_ff);
   assign dist_in = (sum < cfg.min_distance) ? cfg.min_distance : sum;
   assign oor_in  = (dist_in >= cfg.range_limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= head.valid;
         s2_valid_ff <= s1_valid_ff;
         valid_ff    <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_num_ff   <= s1_num_in;
      s1_recip_ff <= ird_pkg::RECIP_TABLE[head.item.seg];
      s1_base_ff  <= head.item.base;
      s1_miss_ff  <= head.item.miss;
      s1_seg_ff   <= head.item.seg;

      s2_quot_ff  <= s2_quot_in;
      s2_base_ff  <= s1_base_ff;
      s2_miss_ff  <= s1_miss_ff;
      s2_seg_ff   <= s1_seg_ff;

      dist_ff     <= dist_in;
      oor_ff      <= oor_in;
      miss_ff     <= s2_miss_ff;
      seg_ff      <= s2_seg_ff;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_distance_cm   = dist_ff;
   assign rsp_out_of_range  = oor_ff;
   assign rsp_no_segment    = miss_ff;
   assign rsp_segment_index = seg_ff;

endmodule

/* rtl/ir_distance_linearizer.sv */
// ----------------------------------------------------------------------------
// ir_distance_linearizer: infrared range sensor linearisation
// Converts a raw converter code into a distance in centimetres by piecewise
// linear interpolation over a fixed thirteen-point calibration table.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------
//  request   start / busy         req_adc_sample
//  response  rsp_valid (strobe)   rsp_distance_cm, rsp_out_of_range,
//                                 rsp_no_segment, rsp_segment_index
//  csr       csr_valid/csr_ready  csr_index, csr_wdata
//
// One transaction may be accepted every clock cycle while busy is low. Its
// response appears on the rsp_ ports once it has passed the classification
// register, the queue entry and the three arithmetic stages.
// Reset is synchronous and active high; it empties the pipeline and the queue
// and restores the floor to 10 cm and the range limit to 51 cm. While reset is
// held, busy is high and csr_ready is low, so no transaction is taken.
// The response side cannot stall, so the back end drains one entry per cycle.
// Outside reset, busy rises only if the queue has filled behind a held front-end entry.
// ----------------------------------------------------------------------------
module ir_distance_linearizer #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          start,
   output logic                          busy,
   input  logic [ird_pkg::SAMPLE_W-1:0]  req_adc_sample,

   output logic                          rsp_valid,
   output logic [ird_pkg::DIST_W-1:0]    rsp_distance_cm,
   output logic                          rsp_out_of_range,
   output logic                          rsp_no_segment,
   output logic [ird_pkg::SEG_W-1:0]     rsp_segment_index,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ird_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ird_pkg::DIST_W-1:0]    csr_wdata
);

   // Configuration registers. Writes to an index outside the register list
   // are acknowledged and dropped.
   ird_pkg::dist_type min_distance_ff;
   ird_pkg::dist_type min_distance_in;
   ird_pkg::dist_type range_limit_ff;
   ird_pkg::dist_type range_limit_in;
   ird_pkg::cfg_type  cfg;

   logic              queue_full;
   logic              push;
   ird_pkg::item_type push_item;
   logic              pop;
   ird_pkg::head_type head;

   assign csr_ready = !reset;

   always_comb begin
      min_distance_in = min_distance_ff;
      range_limit_in  = range_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ird_pkg::CSR_MIN_DISTANCE: min_distance_in = csr_wdata;
            ird_pkg::CSR_RANGE_LIMIT:  range_limit_in  = csr_wdata;
            default: begin
               min_distance_in = min_distance_ff;
               range_limit_in  = range_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff <= ird_pkg::MIN_DISTANCE_RESET;
         range_limit_ff  <= ird_pkg::RANGE_LIMIT_RESET;
      end else begin
         min_distance_ff <= min_distance_in;
         range_limit_ff  <= range_limit_in;
      end
   end

   assign cfg.min_distance = min_distance_ff;
   assign cfg.range_limit  = range_limit_ff;

   // Front end: intake and segment search across all comparators at once.
   ird_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .adc_sample (req_adc_sample),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // The queue lets the front end keep accepting while arithmetic is in flight.
   ird_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (head)
   );

   // Back end: multiply, scale by the segment reciprocal, clamp and compare.
   ird_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .cfg               (cfg),
      .rsp_valid         (rsp_valid),
      .rsp_distance_cm   (rsp_distance_cm),
      .rsp_out_of_range  (rsp_out_of_range),
      .rsp_no_segment    (rsp_no_segment),
      .rsp_segment_index (rsp_segment_index)
   );

   // Every accepted transaction yields its response.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted transaction produced no response on time");

   // No response appears without a matching accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("response without a matching transaction");

   // A sample outside every segment reports segment zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_segment) |-> (rsp_segment_index == '0))
      else $error("unmatched sample reported a nonzero segment");

   // The floor clamp is never undercut.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance_cm >= min_distance_ff))
      else $error("distance below the configured floor");

endmodule
